// ===== design/binary_to_decimal_ascii_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII core
// Shared wrappers that clock on clk_i and hold off during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BDAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define BDAC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bdac_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Beat payload types and constants shared by the core and its parts.
// ----------------------------------------------------------------------------
package bdac_pkg;

  localparam int unsigned NUM_BITS    = 64;
  localparam int unsigned DIGITS_MAX  = 20;
  localparam int unsigned DIG_IDX_W   = $clog2(DIGITS_MAX);
  localparam int unsigned ITER_W      = $clog2(NUM_BITS);
  localparam int unsigned MAX_PAD_DEF = 32;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_NINE  = 8'h39;
  localparam logic [7:0]  ERR_CHAR    = 8'h00;
  localparam logic        STATUS_OK   = 1'b0;
  localparam logic        STATUS_FULL = 1'b1;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [63:0] number;
    logic [5:0]  pad_width;
    logic [7:0]  free_space;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       status;
  } out_beat_t;

  // Status of the conversion unit toward the sequencer.
  typedef struct packed {
    logic                 done;
    logic [DIG_IDX_W-1:0] num_digits;
  } conv_stat_t;

endpackage

// ===== design/bdac_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One beat moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface bdac_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// ===== design/bdac_dabble.sv =====
// ----------------------------------------------------------------------------
// Binary to BCD conversion unit
// Shift-and-add-3 over one binary bit per cycle, then reports digit count.
// ----------------------------------------------------------------------------
module bdac_dabble (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [63:0]           number_i,
  output bdac_pkg::conv_stat_t  stat_o,
  output bdac_pkg::digit_t      digits_o [bdac_pkg::DIGITS_MAX]
);
  import bdac_pkg::*;

  logic [NUM_BITS-1:0] bin_q;
  digit_t              dig_q [DIGITS_MAX];
  digit_t              adj   [DIGITS_MAX];
  logic [ITER_W-1:0]   iter_q;
  logic                busy_q;
  logic                done_q;
  logic [DIG_IDX_W-1:0] nd;

  // Every digit that reached five is corrected before the shift doubles it.
  always_comb begin
    for (int i = 0; i < DIGITS_MAX; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= number_i;
      for (int i = 0; i < DIGITS_MAX; i++) begin
        dig_q[i] <= '0;
      end
    end else if (busy_q) begin
      bin_q    <= {bin_q[NUM_BITS-2:0], 1'b0};
      dig_q[0] <= {adj[0][2:0], bin_q[NUM_BITS-1]};
      for (int i = 1; i < DIGITS_MAX; i++) begin
        dig_q[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(NUM_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Count of significant digits; zero still counts as one digit.
  always_comb begin
    nd = DIG_IDX_W'(1);
    for (int i = 0; i < DIGITS_MAX; i++) begin
      if (dig_q[i] != '0) nd = DIG_IDX_W'(i + 1);
    end
  end

  assign stat_o.done       = done_q;
  assign stat_o.num_digits = nd;
  assign digits_o          = dig_q;

endmodule

// ===== design/binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII core
// Turns an unsigned 64-bit value into zero-padded decimal ASCII characters.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                   Beats per item
//   in_i      in    number[63:0] pad_width[5:0] free_space    1
//   out_o     out   char_code[7:0] last_char status           1 to MAX_PAD
//
// The conversion unit works through the 64 input bits one per cycle, and
// the output register sends one character per cycle while the output is
// not stalled; an item that does not fit sends a single error beat.
// Reset is asynchronous and active low; it clears the sequencer and the
// output valid. The input is ready only while the sequencer is idle, and a
// stalled output holds the sequencer while it emits, with its beat unchanged.
module binary_to_decimal_ascii_core #(
  parameter int unsigned MaxPad = bdac_pkg::MAX_PAD_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdac_stream_if.sink   in_i,
  bdac_stream_if.source out_o
);
  import bdac_pkg::*;

  // Character counts run up to MaxPad, which is never below the digit count.
  localparam int unsigned CntW = $clog2(MaxPad + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   pad_q;
  logic [7:0]        room_q;
  logic [CntW-1:0]   total_q;
  logic [CntW-1:0]   ndig_q;
  logic [CntW-1:0]   rem_q;
  logic              out_valid_q;
  out_beat_t         out_beat_q;

  logic              in_fire;
  logic              out_free;
  logic              too_big;
  logic              out_load;
  logic [6:0]        pad_ext;
  logic [CntW-1:0]   pad_clamped;
  logic [CntW-1:0]   ndig_ext;
  logic [CntW-1:0]   pos;
  digit_t            sel_digit;
  conv_stat_t        conv_stat;
  digit_t            digits [DIGITS_MAX];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // The text does not fit into the free space of the destination.
  assign too_big  = 8'(total_q) > room_q;
  // A new beat enters the output register this cycle.
  assign out_load = out_free && ((state_q == ST_EMIT) || (state_q == ST_CHECK && too_big));

  // Clamp the requested width to MaxPad.
  assign pad_ext     = {1'b0, in_i.payload.pad_width};
  assign pad_clamped = (pad_ext > 7'(MaxPad)) ? CntW'(MaxPad) : CntW'(pad_ext);

  bdac_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .number_i (in_i.payload.number),
    .stat_o   (conv_stat),
    .digits_o (digits)
  );

  assign ndig_ext = CntW'(conv_stat.num_digits);

  // Characters count down from the most significant position; positions at
  // or above the digit count are leading pad zeros.
  assign pos       = rem_q - 1'b1;
  assign sel_digit = digits[pos[DIG_IDX_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_beat_q  <= '0;
      pad_q       <= '0;
      room_q      <= '0;
      total_q     <= '0;
      ndig_q      <= '0;
      rem_q       <= '0;
    end else begin
      // A beat stays valid until it is taken, unless a new one replaces it.
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            pad_q   <= pad_clamped;
            room_q  <= in_i.payload.free_space;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_stat.done) begin
            ndig_q  <= ndig_ext;
            total_q <= (pad_q > ndig_ext) ? pad_q : ndig_ext;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (too_big) begin
            // Not enough room: a single error beat and nothing else.
            if (out_free) begin
              out_beat_q.char_code <= ERR_CHAR;
              out_beat_q.last_char <= 1'b1;
              out_beat_q.status    <= STATUS_FULL;
              state_q              <= ST_IDLE;
            end
          end else begin
            rem_q   <= total_q;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_beat_q.char_code <= (pos >= ndig_q) ? ASCII_ZERO
                                                    : ASCII_ZERO + {4'd0, sel_digit};
            out_beat_q.last_char <= (rem_q == CntW'(1));
            out_beat_q.status    <= STATUS_OK;
            rem_q                <= pos;
            if (rem_q == CntW'(1)) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_beat_q;

endmodule

// ===== design/bdac_checker.sv =====
// ----------------------------------------------------------------------------
// Binary to decimal ASCII port checker
// Watches the core's ports and flags beats that break its rules.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_assert.svh"

module bdac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] char_code_i,
  input logic       last_char_i,
  input logic       status_i
);
  import bdac_pkg::*;

  `BDAC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(char_code_i) && $stable(last_char_i) && $stable(status_i), "stalled output beat changed")
  `BDAC_ASSERT(a_err_beat, !(out_valid_i && status_i == STATUS_FULL) || (last_char_i && char_code_i == ERR_CHAR), "error beat is not a lone final beat with a null character")
  `BDAC_ASSERT(a_digit_char, !(out_valid_i && status_i == STATUS_OK) || (char_code_i >= ASCII_ZERO && char_code_i <= ASCII_NINE), "character beat is not a decimal digit")
  `BDAC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "input still ready while an item is converted")

endmodule

bind binary_to_decimal_ascii_core bdac_checker u_bdac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .char_code_i (out_o.payload.char_code),
  .last_char_i (out_o.payload.last_char),
  .status_i    (out_o.payload.status)
);

// ===== sim/tb_binary_to_decimal_ascii_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the binary to decimal ASCII core
// Offers 64-bit values with pad widths and free space, first from a table
// of corner cases and then at random. Every beat that comes out is checked
// against typed-in text, an error beat or a local model of the decimal conversion.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii_core;

  import bdac_pkg::*;

  localparam int MAX_PAD      = MAX_PAD_DEF;
  localparam int N_ROWS       = 25;
  localparam int N_RANDOM     = 150;
  // This drain covers any beat still in flight once the last expectation has cleared.
  localparam int DRAIN_CYCLES = 150;
  // The limit allows for the slowest legal run: 32 characters per item, the
  // longest receiver stall on each beat and the longest sender gap.
  localparam int CYCLE_LIMIT  = 400000;
  // The receiver takes one long break after this many beats, long enough
  // for the core to fill up and drop its input ready.
  localparam int HOLD_AT_BEAT = 40;
  localparam int HOLD_CYCLES  = 600;

  typedef out_beat_t beat_q_t [$];

  // How a table row gets its expected characters: typed in as text, a
  // single error beat, or worked out by the conversion model.
  typedef enum {CHK_PRED, CHK_TEXT, CHK_FULL} row_chk_e;

  typedef struct {
    logic [63:0] number;
    logic [5:0]  pad_width;
    logic [7:0]  free_space;
    row_chk_e    chk;
    string       text;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bdac_stream_if #(.payload_t(in_beat_t))  in_if ();
  bdac_stream_if #(.payload_t(out_beat_t)) out_if ();

  binary_to_decimal_ascii_core #(
    .MaxPad(MAX_PAD)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Characters still owed by the core, oldest first.
  beat_q_t pending_chars;
  int      error_count = 0;
  int      cycle_count = 0;
  // While set, neither side inserts idle cycles.
  bit      no_idle     = 1'b0;

  // Corner cases. Text is only typed in where it is obvious; the rest is
  // left to the model or set to expect an error beat.
  stim_row_t stim_rows [N_ROWS] = '{
    '{64'd0, 6'd0, 8'd255, CHK_TEXT, "0"},
    // Zero still needs one character, so no room at all is an error.
    '{64'd0, 6'd0, 8'd0, CHK_FULL, ""},
    '{64'd0, 6'd1, 8'd1, CHK_TEXT, "0"},
    '{64'd0, 6'd5, 8'd255, CHK_TEXT, "00000"},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 8'd255, CHK_TEXT, "18446744073709551615"},
    // The largest value fits exactly into 20 characters of room.
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 8'd20, CHK_TEXT, "18446744073709551615"},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 8'd19, CHK_FULL, ""},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 8'd255, CHK_PRED, ""},
    // Pad widths above the maximum are clamped to it.
    '{64'd5, 6'd63, 8'd255, CHK_PRED, ""},
    '{64'd5, 6'd33, 8'd32, CHK_PRED, ""},
    '{64'd5, 6'd33, 8'd31, CHK_FULL, ""},
    '{64'd5, 6'd32, 8'd32, CHK_PRED, ""},
    // Pad widths at or below the digit count add nothing; above it they add leading zeros.
    '{64'd123, 6'd2, 8'd3, CHK_TEXT, "123"},
    '{64'd123, 6'd3, 8'd3, CHK_TEXT, "123"},
    '{64'd123, 6'd5, 8'd5, CHK_TEXT, "00123"},
    '{64'd123, 6'd5, 8'd4, CHK_FULL, ""},
    '{64'd9, 6'd0, 8'd255, CHK_TEXT, "9"},
    '{64'd10, 6'd0, 8'd255, CHK_TEXT, "10"},
    '{64'd9999999999999999999, 6'd0, 8'd255, CHK_TEXT, "9999999999999999999"},
    '{64'd10000000000000000000, 6'd0, 8'd255, CHK_TEXT, "10000000000000000000"},
    '{64'hAAAA_AAAA_AAAA_AAAA, 6'd24, 8'd255, CHK_PRED, ""},
    '{64'h5555_5555_5555_5555, 6'd0, 8'd255, CHK_PRED, ""},
    '{64'h8000_0000_0000_0000, 6'd0, 8'd255, CHK_TEXT, "9223372036854775808"},
    '{64'd1, 6'd20, 8'd0, CHK_FULL, ""},
    '{64'd42, 6'd0, 8'd1, CHK_FULL, ""}
  };

  // Decimal text of one item: leading '0' pad up to the clamped width,
  // then the digits most significant first, or one error beat when the
  // text does not fit into the free space.
  function automatic beat_q_t decimal_text(input in_beat_t item);
    beat_q_t     chars;
    out_beat_t   beat;
    logic [63:0] rest;
    digit_t      digs [DIGITS_MAX];
    int          nd;
    int          pad;
    int          total;
    rest = item.number;
    nd   = 0;
    pad  = (item.pad_width > MAX_PAD) ? MAX_PAD : int'(item.pad_width);
    do begin
      digs[nd] = digit_t'(rest % 64'd10);
      rest     = rest / 64'd10;
      nd++;
    end while (rest != 64'd0 && nd < DIGITS_MAX);
    total = (pad > nd) ? pad : nd;
    if (total > int'(item.free_space)) begin
      beat.char_code = ERR_CHAR;
      beat.last_char = 1'b1;
      beat.status    = STATUS_FULL;
      chars.push_back(beat);
    end else begin
      for (int k = 0; k < total; k++) begin
        // Positions before total - nd are pad; after that, the digit index
        // counts down from the most significant one.
        beat.char_code = (k < total - nd) ? ASCII_ZERO
                                          : ASCII_ZERO + {4'd0, digs[total - 1 - k]};
        beat.last_char = (k + 1 == total);
        beat.status    = STATUS_OK;
        chars.push_back(beat);
      end
    end
    return chars;
  endfunction

  // Random item. Values are spread over all magnitudes, and the free space
  // lands right around the text length in half of the draws, so that both the
  // exact fit and the error by one character come up often.
  function automatic in_beat_t random_item();
    in_beat_t    item;
    logic [63:0] p;
    int          total;
    case ($urandom_range(0, 3))
      0: item.number = {$urandom, $urandom};
      1: item.number = 64'($urandom_range(0, 999));
      2: item.number = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: begin
        // Powers of ten and the value just below them change digit count.
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        item.number = p - 64'($urandom_range(0, 1));
      end
    endcase
    item.pad_width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, MAX_PAD));
    item.free_space = 8'd255;
    total = decimal_text(item).size();
    case ($urandom_range(0, 5))
      0:       item.free_space = 8'($urandom_range(0, 255));
      1:       item.free_space = 8'(total - 1);
      2:       item.free_space = 8'(total);
      3:       item.free_space = 8'(total + 1);
      default: item.free_space = 8'd255;
    endcase
    return item;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // Offers one item after a random gap and waits for the input beat. The
  // characters it owes are queued at the edge that takes it. Valid stays
  // high across back-to-back items, so it is never lowered and raised in
  // the same step.
  task automatic offer_item(input in_beat_t item, input beat_q_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk_i); while (!in_if.ready);
    foreach (want[i]) pending_chars.push_back(want[i]);
  endtask

  // Sender: reset, the corner-case table, the random items, then the drain
  // and the verdict.
  initial begin
    in_beat_t  item;
    beat_q_t   want;
    out_beat_t beat;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[r]) begin
      item.number     = stim_rows[r].number;
      item.pad_width  = stim_rows[r].pad_width;
      item.free_space = stim_rows[r].free_space;
      want.delete();
      case (stim_rows[r].chk)
        CHK_TEXT: begin
          for (int i = 0; i < stim_rows[r].text.len(); i++) begin
            beat.char_code = stim_rows[r].text[i];
            beat.last_char = (i + 1 == stim_rows[r].text.len());
            beat.status    = STATUS_OK;
            want.push_back(beat);
          end
        end
        CHK_FULL: begin
          beat.char_code = ERR_CHAR;
          beat.last_char = 1'b1;
          beat.status    = STATUS_FULL;
          want.push_back(beat);
        end
        default: want = decimal_text(item);
      endcase
      offer_item(item, want);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // A window of items with no idle cycles on either side.
      no_idle = (n >= 50 && n < 80);
      item    = random_item();
      offer_item(item, decimal_text(item));
    end
    no_idle = 1'b0;
    @(posedge clk_i);
    in_if.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_binary_to_decimal_ascii_core: done, clean");
    end else begin
      $display("tb_binary_to_decimal_ascii_core: done, errors");
    end
    $finish;
  end

  // Receiver: a random wait before each beat, and once a long hold-off
  // while the sender keeps offering, so the core backs up to its input.
  initial begin
    int gap;
    int beats_taken;
    beats_taken   = 0;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (beats_taken == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      beats_taken++;
    end
  end

  // Each output beat is checked against the oldest owed character.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("beat with nothing owed: char %02h last %0b status %0b",
                                  out_if.payload.char_code, out_if.payload.last_char,
                                  out_if.payload.status));
      end else begin
        want = pending_chars.pop_front();
        if (out_if.payload.char_code !== want.char_code) begin
          report_mismatch($sformatf("char_code %02h, want %02h",
                                    out_if.payload.char_code, want.char_code));
        end
        if (out_if.payload.last_char !== want.last_char) begin
          report_mismatch($sformatf("last_char %0b, want %0b",
                                    out_if.payload.last_char, want.last_char));
        end
        if (out_if.payload.status !== want.status) begin
          report_mismatch($sformatf("status %0b, want %0b",
                                    out_if.payload.status, want.status));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_binary_to_decimal_ascii_core: done, errors");
      $finish;
    end
  end

endmodule

// ===== binary_to_decimal_ascii_core.f =====
+incdir+design
design/bdac_pkg.sv
design/bdac_stream_if.sv
design/bdac_dabble.sv
design/binary_to_decimal_ascii_core.sv
design/bdac_checker.sv
sim/tb_binary_to_decimal_ascii_core.sv
